@@ sv/pdd_pkg.sv @@
// Shared types, codes and helper functions for the posture deviation dwell detector.
package pdd_pkg;

    localparam int CFG_W      = 6;
    localparam int PITCH_W    = 11;
    localparam int DEV_W      = 12;
    localparam int MAG_W      = 11;
    localparam int DWELL_W    = 16;
    localparam int WORD_W     = 32;
    localparam int DUR_W      = 23;
    localparam int ADDR_W     = 5;
    localparam int IDX_W      = 3;

    localparam logic [CFG_W-1:0]   CFG_MIN       = 6'd1;
    localparam logic [CFG_W-1:0]   CFG_MAX       = 6'd60;
    localparam logic [CFG_W-1:0]   THRESHOLD_RST = 6'd15;
    localparam logic [CFG_W-1:0]   SUSTAIN_RST   = 6'd5;
    localparam logic [CFG_W-1:0]   RECOVER_RST   = 6'd5;
    localparam logic [DWELL_W-1:0] DWELL_MAX     = 16'hFFFF;
    localparam logic [WORD_W-1:0]  MS_PER_SEC    = 32'd1000;
    localparam logic [9:0]         DEG_TO_X10    = 10'd10;
    // ceil(2^35 / 125): exact quotient of a 29-bit value by 125.
    localparam logic [28:0]        RECIP_125     = 29'd274877907;

    typedef enum logic [1:0] {
        POSTURE_UNKNOWN = 2'd0,
        POSTURE_UPRIGHT = 2'd1,
        POSTURE_SLOUCH  = 2'd2
    } posture_t;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_CALIBRATE   = 2'd1,
        OP_STATS_CLEAR = 2'd2,
        OP_UNUSED      = 2'd3
    } opcode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_THRESHOLD    = 3'd0,
        REG_SUSTAIN      = 3'd1,
        REG_RECOVER      = 3'd2,
        REG_PRESET_BASE  = 3'd3,
        REG_PRESET_VALID = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] threshold_deg;
        logic [CFG_W-1:0] slouch_delay;
        logic [CFG_W-1:0] recover_sec;
    } cfg_t;

    typedef struct packed {
        logic                      baseline_we;
        logic signed [PITCH_W-1:0] baseline;
        logic                      valid_we;
        logic                      valid;
    } preset_load_t;

    function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        begin
            r = v;
            if (v < CFG_MIN)
            begin
                r = CFG_MIN;
            end
            else if (v > CFG_MAX)
            begin
                r = CFG_MAX;
            end
            return r;
        end
    endfunction

    // Milliseconds to whole seconds: divide by 8 with a shift, then by 125
    // through a reciprocal multiply.
    function automatic logic [DUR_W-1:0] ms_to_sec(input logic [WORD_W-1:0] ms);
        logic [28:0] eighths;
        logic [57:0] prod;
        begin
            eighths = ms[WORD_W-1:3];
            prod    = {29'd0, eighths} * {29'd0, RECIP_125};
            return prod[57:35];
        end
    endfunction

endpackage

@@ sv/pdd_regs.sv @@
// APB-style configuration register file with clamped dwell settings.
module pdd_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pdd_pkg::ADDR_W-1:0]        paddr,
    input  logic [pdd_pkg::WORD_W-1:0]        pwdata,
    output logic [pdd_pkg::WORD_W-1:0]        prdata,
    output logic                              pready,
    output pdd_pkg::cfg_t                     cfg,
    output pdd_pkg::preset_load_t             preset_load
);

    logic [pdd_pkg::CFG_W-1:0]          threshold_reg;
    logic [pdd_pkg::CFG_W-1:0]          sustain_reg;
    logic [pdd_pkg::CFG_W-1:0]          recover_reg;
    logic signed [pdd_pkg::PITCH_W-1:0] preset_base_reg;
    logic                               preset_valid_reg;
    logic                               wr_en;
    pdd_pkg::reg_idx_t                  idx;
    logic [pdd_pkg::CFG_W-1:0]          wr_clamped;

    assign pready     = 1'b1;
    assign wr_en      = psel && penable && pwrite;
    assign idx        = pdd_pkg::reg_idx_t'(paddr[pdd_pkg::ADDR_W-1:2]);
    assign wr_clamped = pdd_pkg::clamp_cfg(pwdata[pdd_pkg::CFG_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= pdd_pkg::THRESHOLD_RST;
            sustain_reg      <= pdd_pkg::SUSTAIN_RST;
            recover_reg      <= pdd_pkg::RECOVER_RST;
            preset_base_reg  <= '0;
            preset_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (idx)
                pdd_pkg::REG_THRESHOLD:    threshold_reg    <= wr_clamped;
                pdd_pkg::REG_SUSTAIN:      sustain_reg      <= wr_clamped;
                pdd_pkg::REG_RECOVER:      recover_reg      <= wr_clamped;
                pdd_pkg::REG_PRESET_BASE:  preset_base_reg  <= pwdata[pdd_pkg::PITCH_W-1:0];
                pdd_pkg::REG_PRESET_VALID: preset_valid_reg <= pwdata[0];
                default:                   ;
            endcase
        end
    end

    // Preset writes also load the live baseline and calibration flag.
    always_comb
    begin
        preset_load.baseline_we = wr_en && (idx == pdd_pkg::REG_PRESET_BASE);
        preset_load.baseline    = pwdata[pdd_pkg::PITCH_W-1:0];
        preset_load.valid_we    = wr_en && (idx == pdd_pkg::REG_PRESET_VALID);
        preset_load.valid       = pwdata[0];
    end

    assign cfg.threshold_deg = threshold_reg;
    assign cfg.slouch_delay  = sustain_reg;
    assign cfg.recover_sec   = recover_reg;

    always_comb
    begin
        case (idx)
            pdd_pkg::REG_THRESHOLD:    prdata = {26'd0, threshold_reg};
            pdd_pkg::REG_SUSTAIN:      prdata = {26'd0, sustain_reg};
            pdd_pkg::REG_RECOVER:      prdata = {26'd0, recover_reg};
            pdd_pkg::REG_PRESET_BASE:  prdata = {{21{preset_base_reg[10]}}, preset_base_reg};
            pdd_pkg::REG_PRESET_VALID: prdata = {31'd0, preset_valid_reg};
            default:                   prdata = '0;
        endcase
    end

endmodule

@@ sv/pdd_tracker.sv @@
// Input register, posture state and statistics update, and result register.
module pdd_tracker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  pdd_pkg::cfg_t                      cfg,
    input  pdd_pkg::preset_load_t              preset_load,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         opcode,
    input  logic signed [pdd_pkg::PITCH_W-1:0] pitch_x10,
    input  logic [pdd_pkg::WORD_W-1:0]         now_ms,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         posture,
    output logic signed [pdd_pkg::DEV_W-1:0]   deviation_x10,
    output logic [pdd_pkg::WORD_W-1:0]         session_count,
    output logic [pdd_pkg::WORD_W-1:0]         slouch_time_sec,
    output logic [pdd_pkg::DUR_W-1:0]          longest_session_sec,
    output logic [pdd_pkg::WORD_W-1:0]         since_upright_sec,
    output logic                               event_valid,
    output logic [pdd_pkg::WORD_W-1:0]         event_start_ms,
    output logic [pdd_pkg::DUR_W-1:0]          event_duration_sec,
    output logic [pdd_pkg::MAG_W-1:0]          event_peak_dev_x10
);

    // Input stage.
    logic                               in_valid_reg;
    pdd_pkg::opcode_t                   op_reg;
    logic signed [pdd_pkg::PITCH_W-1:0] pitch_reg;
    logic [pdd_pkg::WORD_W-1:0]         now_reg;

    // Tracking state.
    pdd_pkg::posture_t                  posture_reg, posture_next;
    logic signed [pdd_pkg::PITCH_W-1:0] baseline_reg, baseline_next;
    logic                               calibrated_reg, calibrated_next;
    logic [pdd_pkg::DWELL_W-1:0]        above_reg, above_next;
    logic [pdd_pkg::DWELL_W-1:0]        below_reg, below_next;
    logic [pdd_pkg::WORD_W-1:0]         start_reg, start_next;
    logic [pdd_pkg::MAG_W-1:0]          peak_reg, peak_next;
    logic [pdd_pkg::WORD_W-1:0]         sessions_reg, sessions_next;
    logic [pdd_pkg::WORD_W-1:0]         slouch_reg, slouch_next;
    logic [pdd_pkg::DUR_W-1:0]          longest_reg, longest_next;
    logic [pdd_pkg::WORD_W-1:0]         upright_reg, upright_next;
    logic [pdd_pkg::WORD_W-1:0]         seconds_reg, seconds_next;

    // Result stage.
    logic                               out_valid_reg;
    pdd_pkg::posture_t                  res_posture_reg;
    logic signed [pdd_pkg::DEV_W-1:0]   res_dev_reg, res_dev_next;
    logic [pdd_pkg::WORD_W-1:0]         res_since_reg, res_since_next;
    logic                               res_ev_reg, res_ev_next;
    logic [pdd_pkg::WORD_W-1:0]         res_ev_start_reg, res_ev_start_next;
    logic [pdd_pkg::DUR_W-1:0]          res_ev_dur_reg, res_ev_dur_next;
    logic [pdd_pkg::MAG_W-1:0]          res_ev_peak_reg, res_ev_peak_next;
    logic [pdd_pkg::WORD_W-1:0]         res_sessions_reg;
    logic [pdd_pkg::WORD_W-1:0]         res_slouch_reg;
    logic [pdd_pkg::DUR_W-1:0]          res_longest_reg;

    logic                               advance;
    logic                               fire;
    logic signed [pdd_pkg::DEV_W-1:0]   dev;
    logic [pdd_pkg::DEV_W-1:0]          dev_abs;
    logic [pdd_pkg::MAG_W-1:0]          mag;
    logic [9:0]                         thr_x10;
    logic [pdd_pkg::DWELL_W-1:0]        above_inc;
    logic [pdd_pkg::DWELL_W-1:0]        below_inc;
    logic [pdd_pkg::WORD_W-1:0]         sustain_ms;
    logic [pdd_pkg::DUR_W-1:0]          dur;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= pdd_pkg::opcode_t'(opcode);
            pitch_reg <= pitch_x10;
            now_reg   <= now_ms;
        end
    end

    assign dev       = {pitch_reg[10], pitch_reg} - {baseline_reg[10], baseline_reg};
    assign dev_abs   = dev[pdd_pkg::DEV_W-1] ? -dev : dev;
    assign mag       = dev_abs[pdd_pkg::MAG_W-1:0];
    assign thr_x10   = {4'd0, cfg.threshold_deg} * pdd_pkg::DEG_TO_X10;
    assign above_inc = (above_reg == pdd_pkg::DWELL_MAX) ? above_reg : above_reg + 16'd1;
    assign below_inc = (below_reg == pdd_pkg::DWELL_MAX) ? below_reg : below_reg + 16'd1;
    assign sustain_ms = {26'd0, cfg.slouch_delay} * pdd_pkg::MS_PER_SEC;
    assign dur       = pdd_pkg::ms_to_sec(now_reg - start_reg);

    always_comb
    begin
        posture_next      = posture_reg;
        baseline_next     = baseline_reg;
        calibrated_next   = calibrated_reg;
        above_next        = above_reg;
        below_next        = below_reg;
        start_next        = start_reg;
        peak_next         = peak_reg;
        sessions_next     = sessions_reg;
        slouch_next       = slouch_reg;
        longest_next      = longest_reg;
        upright_next      = upright_reg;
        seconds_next      = seconds_reg;
        res_ev_next       = 1'b0;
        res_ev_start_next = '0;
        res_ev_dur_next   = '0;
        res_ev_peak_next  = '0;

        case (op_reg)
            pdd_pkg::OP_TICK:
            begin
                seconds_next = seconds_reg + 32'd1;
                if (!calibrated_reg)
                begin
                    posture_next = pdd_pkg::POSTURE_UNKNOWN;
                end
                else if (mag > {1'b0, thr_x10})
                begin
                    above_next = above_inc;
                    below_next = '0;
                    if (posture_reg == pdd_pkg::POSTURE_SLOUCH)
                    begin
                        if (mag > peak_reg)
                        begin
                            peak_next = mag;
                        end
                        slouch_next = slouch_reg + 32'd1;
                    end
                    else if (above_inc >= {10'd0, cfg.slouch_delay})
                    begin
                        posture_next  = pdd_pkg::POSTURE_SLOUCH;
                        start_next    = now_reg - sustain_ms;
                        peak_next     = mag;
                        sessions_next = sessions_reg + 32'd1;
                        slouch_next   = slouch_reg + {26'd0, cfg.slouch_delay};
                    end
                end
                else
                begin
                    below_next = below_inc;
                    above_next = '0;
                    if (posture_reg == pdd_pkg::POSTURE_SLOUCH)
                    begin
                        if (below_inc >= {10'd0, cfg.recover_sec})
                        begin
                            if (dur > longest_reg)
                            begin
                                longest_next = dur;
                            end
                            res_ev_next       = 1'b1;
                            res_ev_start_next = start_reg;
                            res_ev_dur_next   = dur;
                            res_ev_peak_next  = peak_reg;
                            posture_next      = pdd_pkg::POSTURE_UPRIGHT;
                            upright_next      = seconds_reg + 32'd1;
                        end
                        else
                        begin
                            slouch_next = slouch_reg + 32'd1;
                        end
                    end
                    else
                    begin
                        posture_next = pdd_pkg::POSTURE_UPRIGHT;
                        upright_next = seconds_reg + 32'd1;
                    end
                end
            end
            pdd_pkg::OP_CALIBRATE:
            begin
                baseline_next   = pitch_reg;
                calibrated_next = 1'b1;
                posture_next    = pdd_pkg::POSTURE_UPRIGHT;
                above_next      = '0;
                below_next      = '0;
            end
            pdd_pkg::OP_STATS_CLEAR:
            begin
                sessions_next = '0;
                slouch_next   = '0;
                longest_next  = '0;
                above_next    = '0;
                below_next    = '0;
                start_next    = '0;
                peak_next     = '0;
            end
            default:
            begin
            end
        endcase

        res_dev_next = {pitch_reg[10], pitch_reg} - {baseline_next[10], baseline_next};
        if ((upright_next == '0) || (seconds_next < upright_next))
        begin
            res_since_next = '0;
        end
        else
        begin
            res_since_next = seconds_next - upright_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            posture_reg    <= pdd_pkg::POSTURE_UNKNOWN;
            baseline_reg   <= '0;
            calibrated_reg <= 1'b0;
            above_reg      <= '0;
            below_reg      <= '0;
            start_reg      <= '0;
            peak_reg       <= '0;
            sessions_reg   <= '0;
            slouch_reg     <= '0;
            longest_reg    <= '0;
            upright_reg    <= '0;
            seconds_reg    <= '0;
        end
        else if (fire)
        begin
            posture_reg    <= posture_next;
            baseline_reg   <= baseline_next;
            calibrated_reg <= calibrated_next;
            above_reg      <= above_next;
            below_reg      <= below_next;
            start_reg      <= start_next;
            peak_reg       <= peak_next;
            sessions_reg   <= sessions_next;
            slouch_reg     <= slouch_next;
            longest_reg    <= longest_next;
            upright_reg    <= upright_next;
            seconds_reg    <= seconds_next;
        end
        else
        begin
            // Preset writes must arrive only while no transaction is in flight; the block does not enforce it.
            if (preset_load.baseline_we)
            begin
                baseline_reg <= preset_load.baseline;
            end
            if (preset_load.valid_we)
            begin
                calibrated_reg <= preset_load.valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_posture_reg  <= posture_next;
            res_dev_reg      <= res_dev_next;
            res_sessions_reg <= sessions_next;
            res_slouch_reg   <= slouch_next;
            res_longest_reg  <= longest_next;
            res_since_reg    <= res_since_next;
            res_ev_reg       <= res_ev_next;
            res_ev_start_reg <= res_ev_start_next;
            res_ev_dur_reg   <= res_ev_dur_next;
            res_ev_peak_reg  <= res_ev_peak_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign posture             = res_posture_reg;
    assign deviation_x10       = res_dev_reg;
    assign session_count       = res_sessions_reg;
    assign slouch_time_sec     = res_slouch_reg;
    assign longest_session_sec = res_longest_reg;
    assign since_upright_sec   = res_since_reg;
    assign event_valid         = res_ev_reg;
    assign event_start_ms      = res_ev_start_reg;
    assign event_duration_sec  = res_ev_dur_reg;
    assign event_peak_dev_x10  = res_ev_peak_reg;

    // A finished session always leaves the detector upright.
    a_event_upright: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_ev_reg |-> res_posture_reg == pdd_pkg::POSTURE_UPRIGHT)
        else $error("session event without upright posture");

    // The two dwell counters never run at the same time.
    a_dwell_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        above_reg != '0 |-> below_reg == '0)
        else $error("above and below dwell counters both nonzero");

    // A new session is counted only on entry into the slouching state.
    a_session_entry: assert property (@(posedge clk) disable iff (!rst_n)
        fire && op_reg == pdd_pkg::OP_TICK && sessions_next != sessions_reg
        |-> posture_next == pdd_pkg::POSTURE_SLOUCH
            && posture_reg != pdd_pkg::POSTURE_SLOUCH)
        else $error("session counted outside slouch entry");

    // A held transaction in the input stage is not lost while the result stalls.
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(now_reg))
        else $error("input stage dropped a stalled transaction");

endmodule

@@ sv/posture_deviation_dwell_detector_unit.sv @@
// Top level of the posture deviation dwell detector: config port plus tracker.
// Each transaction is latched into an input register and resolved by the
// update logic into the result register, which drives the outputs, and a new
// transaction can be taken every cycle while the result side keeps up. The
// input register also holds one transaction while a result waits to be taken.
// The longest path per cycle is the session duration: a 32-bit subtract
// followed by a shift and a 29 x 29 reciprocal multiply that together divide
// by 1000, and the compare against the longest session. Configuration
// writes through the APB-style port take effect at once and must be made only
// while no transaction is in flight.
module posture_deviation_dwell_detector_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pdd_pkg::ADDR_W-1:0]         paddr,
    input  logic [pdd_pkg::WORD_W-1:0]         pwdata,
    output logic [pdd_pkg::WORD_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         opcode,
    input  logic signed [pdd_pkg::PITCH_W-1:0] pitch_x10,
    input  logic [pdd_pkg::WORD_W-1:0]         now_ms,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         posture,
    output logic signed [pdd_pkg::DEV_W-1:0]   deviation_x10,
    output logic [pdd_pkg::WORD_W-1:0]         session_count,
    output logic [pdd_pkg::WORD_W-1:0]         slouch_time_sec,
    output logic [pdd_pkg::DUR_W-1:0]          longest_session_sec,
    output logic [pdd_pkg::WORD_W-1:0]         since_upright_sec,
    output logic                               event_valid,
    output logic [pdd_pkg::WORD_W-1:0]         event_start_ms,
    output logic [pdd_pkg::DUR_W-1:0]          event_duration_sec,
    output logic [pdd_pkg::MAG_W-1:0]          event_peak_dev_x10
);

    pdd_pkg::cfg_t         cfg;
    pdd_pkg::preset_load_t preset_load;

    pdd_regs u_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cfg         (cfg),
        .preset_load (preset_load)
    );

    pdd_tracker u_tracker
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg),
        .preset_load         (preset_load),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .opcode              (opcode),
        .pitch_x10           (pitch_x10),
        .now_ms              (now_ms),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .posture             (posture),
        .deviation_x10       (deviation_x10),
        .session_count       (session_count),
        .slouch_time_sec     (slouch_time_sec),
        .longest_session_sec (longest_session_sec),
        .since_upright_sec   (since_upright_sec),
        .event_valid         (event_valid),
        .event_start_ms      (event_start_ms),
        .event_duration_sec  (event_duration_sec),
        .event_peak_dev_x10  (event_peak_dev_x10)
    );

endmodule

@@ tb/posture_deviation_dwell_detector_unit_tb.sv @@
// Self-checking testbench for the posture deviation dwell detector top level.
module posture_deviation_dwell_detector_unit_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 95;
    localparam int N_PHASES       = 4;
    localparam int N_REGS         = 5;
    localparam int N_DIR          = 24;
    localparam int END_WAIT       = 10;

    // An index with no register behind it; writes to it must be ignored.
    localparam logic [pdd_pkg::IDX_W-1:0] REG_NONE = 3'd5;

    typedef struct {
        pdd_pkg::posture_t          posture;
        logic [pdd_pkg::DEV_W-1:0]  dev;
        logic [pdd_pkg::WORD_W-1:0] sessions;
        logic [pdd_pkg::WORD_W-1:0] slouch;
        logic [pdd_pkg::DUR_W-1:0]  longest;
        logic [pdd_pkg::WORD_W-1:0] since;
        logic                       evt_valid;
        logic [pdd_pkg::WORD_W-1:0] evt_start;
        logic [pdd_pkg::DUR_W-1:0]  evt_dur;
        logic [pdd_pkg::MAG_W-1:0]  evt_peak;
    } status_t;

    typedef struct packed {
        pdd_pkg::opcode_t           op;
        int                         pitch;
        logic [pdd_pkg::WORD_W-1:0] now;
        logic                       typed;
        pdd_pkg::posture_t          post;
        int                         dev;
    } dir_row_t;

    // Posture and deviation are typed in only where they are plain to see.
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{pdd_pkg::OP_TICK,        0,     32'd0,         1'b1, pdd_pkg::POSTURE_UNKNOWN, 0},
        '{pdd_pkg::OP_TICK,        1023,  32'd1000,      1'b1, pdd_pkg::POSTURE_UNKNOWN, 1023},
        '{pdd_pkg::OP_TICK,        -1024, 32'd2000,      1'b1, pdd_pkg::POSTURE_UNKNOWN, -1024},
        '{pdd_pkg::OP_UNUSED,      5,     32'hFFFF_FFFF, 1'b1, pdd_pkg::POSTURE_UNKNOWN, 5},
        '{pdd_pkg::OP_STATS_CLEAR, 0,     32'hFFFF_FFFF, 1'b1, pdd_pkg::POSTURE_UNKNOWN, 0},
        '{pdd_pkg::OP_CALIBRATE,   -1024, 32'd5000,      1'b1, pdd_pkg::POSTURE_UPRIGHT, 0},
        '{pdd_pkg::OP_TICK,        1023,  32'd6000,      1'b1, pdd_pkg::POSTURE_UPRIGHT, 2047},
        '{pdd_pkg::OP_CALIBRATE,   1023,  32'd7000,      1'b1, pdd_pkg::POSTURE_UPRIGHT, 0},
        '{pdd_pkg::OP_TICK,        -1024, 32'd8000,      1'b1, pdd_pkg::POSTURE_UPRIGHT, -2047},
        '{pdd_pkg::OP_CALIBRATE,   0,     32'd9000,      1'b1, pdd_pkg::POSTURE_UPRIGHT, 0},
        '{pdd_pkg::OP_TICK,        0,     32'd10000,     1'b1, pdd_pkg::POSTURE_UPRIGHT, 0},
        '{pdd_pkg::OP_TICK,        200,   32'd0,         1'b0, pdd_pkg::POSTURE_UNKNOWN, 0},
        '{pdd_pkg::OP_TICK,        200,   32'd1000,      1'b0, pdd_pkg::POSTURE_UNKNOWN, 0},
        '{pdd_pkg::OP_TICK,        200,   32'd2000,      1'b0, pdd_pkg::POSTURE_UNKNOWN, 0},
        '{pdd_pkg::OP_TICK,        200,   32'd3000,      1'b0, pdd_pkg::POSTURE_UNKNOWN, 0},
        '{pdd_pkg::OP_TICK,        -400,  32'd4000,      1'b0, pdd_pkg::POSTURE_UNKNOWN, 0},
        '{pdd_pkg::OP_TICK,        900,   32'd5000,      1'b0, pdd_pkg::POSTURE_UNKNOWN, 0},
        '{pdd_pkg::OP_TICK,        -300,  32'd6000,      1'b0, pdd_pkg::POSTURE_UNKNOWN, 0},
        '{pdd_pkg::OP_TICK,        150,   32'd7000,      1'b0, pdd_pkg::POSTURE_UNKNOWN, 0},
        '{pdd_pkg::OP_TICK,        150,   32'd8000,      1'b0, pdd_pkg::POSTURE_UNKNOWN, 0},
        '{pdd_pkg::OP_TICK,        150,   32'd9000,      1'b0, pdd_pkg::POSTURE_UNKNOWN, 0},
        '{pdd_pkg::OP_TICK,        -150,  32'd10000,     1'b0, pdd_pkg::POSTURE_UNKNOWN, 0},
        '{pdd_pkg::OP_TICK,        150,   32'd11000,     1'b0, pdd_pkg::POSTURE_UNKNOWN, 0},
        '{pdd_pkg::OP_STATS_CLEAR, -1,    32'd12000,     1'b0, pdd_pkg::POSTURE_UNKNOWN, 0}
    };

    // Register values per phase, in register order; several are out of range on purpose.
    localparam logic [pdd_pkg::WORD_W-1:0] PHASE_CFG [N_PHASES][N_REGS] = '{
        '{32'd0,  32'd1,  32'd1,  32'd1023,       32'd1},
        '{32'd63, 32'd60, 32'd2,  32'hFFFF_FC00,  32'd1},
        '{32'd20, 32'd3,  32'd61, 32'hFFFF_FFB3,  32'd0},
        '{32'd8,  32'd70, 32'd4,  32'h0000_0C00,  32'd3}
    };
    localparam int SEND_IDLE  [N_PHASES] = '{0, 65, 0, 11};
    localparam int RECV_STALL [N_PHASES] = '{0, 0, 65, 11};

    logic                                clk;
    logic                                rst_n     = 1'b0;
    logic                                psel      = 1'b0;
    logic                                penable   = 1'b0;
    logic                                pwrite    = 1'b0;
    logic [pdd_pkg::ADDR_W-1:0]          paddr     = '0;
    logic [pdd_pkg::WORD_W-1:0]          pwdata    = '0;
    logic [pdd_pkg::WORD_W-1:0]          prdata;
    logic                                pready;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    logic [1:0]                          opcode    = '0;
    logic signed [pdd_pkg::PITCH_W-1:0]  pitch_x10 = '0;
    logic [pdd_pkg::WORD_W-1:0]          now_ms    = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [1:0]                          posture;
    logic signed [pdd_pkg::DEV_W-1:0]    deviation_x10;
    logic [pdd_pkg::WORD_W-1:0]          session_count;
    logic [pdd_pkg::WORD_W-1:0]          slouch_time_sec;
    logic [pdd_pkg::DUR_W-1:0]           longest_session_sec;
    logic [pdd_pkg::WORD_W-1:0]          since_upright_sec;
    logic                                event_valid;
    logic [pdd_pkg::WORD_W-1:0]          event_start_ms;
    logic [pdd_pkg::DUR_W-1:0]           event_duration_sec;
    logic [pdd_pkg::MAG_W-1:0]           event_peak_dev_x10;

    // Mirror of the detector's settings and tracking state.
    logic [pdd_pkg::CFG_W-1:0]           thr_deg;
    logic [pdd_pkg::CFG_W-1:0]           sus_sec;
    logic [pdd_pkg::CFG_W-1:0]           rec_sec;
    logic signed [pdd_pkg::PITCH_W-1:0]  base_x10;
    logic                                calib;
    pdd_pkg::posture_t                   pstate;
    logic [pdd_pkg::DWELL_W-1:0]         above_cnt;
    logic [pdd_pkg::DWELL_W-1:0]         below_cnt;
    logic [pdd_pkg::WORD_W-1:0]          sess_start;
    logic [pdd_pkg::MAG_W-1:0]           sess_peak;
    logic [pdd_pkg::WORD_W-1:0]          n_sessions;
    logic [pdd_pkg::WORD_W-1:0]          slouch_secs;
    logic [pdd_pkg::WORD_W-1:0]          longest_sec;
    logic [pdd_pkg::WORD_W-1:0]          last_up;
    logic [pdd_pkg::WORD_W-1:0]          secs_now;

    status_t                    posture_status_q [$];
    int unsigned                err_cnt       = 0;
    int unsigned                quiet_cycles  = 0;
    int                         send_idle_pct = 0;
    int                         recv_stall_pct = 0;

    posture_deviation_dwell_detector_unit u_dut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .opcode              (opcode),
        .pitch_x10           (pitch_x10),
        .now_ms              (now_ms),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .posture             (posture),
        .deviation_x10       (deviation_x10),
        .session_count       (session_count),
        .slouch_time_sec     (slouch_time_sec),
        .longest_session_sec (longest_session_sec),
        .since_upright_sec   (since_upright_sec),
        .event_valid         (event_valid),
        .event_start_ms      (event_start_ms),
        .event_duration_sec  (event_duration_sec),
        .event_peak_dev_x10  (event_peak_dev_x10)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Advances the tracking state by one transaction and returns the status it reports.
    function automatic status_t track_posture(input pdd_pkg::opcode_t op,
                                              input logic signed [pdd_pkg::PITCH_W-1:0] pitch,
                                              input logic [pdd_pkg::WORD_W-1:0] now);
        status_t                    s;
        int                         dev;
        int                         mag;
        logic [pdd_pkg::WORD_W-1:0] dur;
        begin
            s.evt_valid = 1'b0;
            s.evt_start = '0;
            s.evt_dur   = '0;
            s.evt_peak  = '0;
            case (op)
                pdd_pkg::OP_TICK:
                begin
                    secs_now = secs_now + 1;
                    if (!calib)
                    begin
                        pstate = pdd_pkg::POSTURE_UNKNOWN;
                    end
                    else
                    begin
                        dev = int'(pitch) - int'(base_x10);
                        mag = (dev < 0) ? -dev : dev;
                        if (mag > int'(thr_deg) * 10)
                        begin
                            if (above_cnt != pdd_pkg::DWELL_MAX)
                            begin
                                above_cnt = above_cnt + 16'd1;
                            end
                            below_cnt = '0;
                            if (pstate == pdd_pkg::POSTURE_SLOUCH)
                            begin
                                if (mag > int'(sess_peak))
                                begin
                                    sess_peak = mag[pdd_pkg::MAG_W-1:0];
                                end
                                slouch_secs = slouch_secs + 1;
                            end
                            else if (above_cnt >= pdd_pkg::DWELL_W'(sus_sec))
                            begin
                                // The session is dated back to the start of the sustain dwell.
                                pstate      = pdd_pkg::POSTURE_SLOUCH;
                                sess_start  = now - pdd_pkg::WORD_W'(sus_sec)
                                                    * pdd_pkg::MS_PER_SEC;
                                sess_peak   = mag[pdd_pkg::MAG_W-1:0];
                                n_sessions  = n_sessions + 1;
                                slouch_secs = slouch_secs + pdd_pkg::WORD_W'(sus_sec);
                            end
                        end
                        else
                        begin
                            if (below_cnt != pdd_pkg::DWELL_MAX)
                            begin
                                below_cnt = below_cnt + 16'd1;
                            end
                            above_cnt = '0;
                            if (pstate == pdd_pkg::POSTURE_SLOUCH)
                            begin
                                if (below_cnt >= pdd_pkg::DWELL_W'(rec_sec))
                                begin
                                    dur = (now - sess_start) / pdd_pkg::MS_PER_SEC;
                                    if (dur > longest_sec)
                                    begin
                                        longest_sec = dur;
                                    end
                                    s.evt_valid = 1'b1;
                                    s.evt_start = sess_start;
                                    s.evt_dur   = dur[pdd_pkg::DUR_W-1:0];
                                    s.evt_peak  = sess_peak;
                                    pstate      = pdd_pkg::POSTURE_UPRIGHT;
                                    last_up     = secs_now;
                                end
                                else
                                begin
                                    slouch_secs = slouch_secs + 1;
                                end
                            end
                            else
                            begin
                                pstate  = pdd_pkg::POSTURE_UPRIGHT;
                                last_up = secs_now;
                            end
                        end
                    end
                end
                pdd_pkg::OP_CALIBRATE:
                begin
                    base_x10  = pitch;
                    calib     = 1'b1;
                    pstate    = pdd_pkg::POSTURE_UPRIGHT;
                    above_cnt = '0;
                    below_cnt = '0;
                end
                pdd_pkg::OP_STATS_CLEAR:
                begin
                    n_sessions  = '0;
                    slouch_secs = '0;
                    longest_sec = '0;
                    above_cnt   = '0;
                    below_cnt   = '0;
                    sess_start  = '0;
                    sess_peak   = '0;
                end
                default:
                begin
                end
            endcase
            dev        = int'(pitch) - int'(base_x10);
            s.posture  = pstate;
            s.dev      = dev[pdd_pkg::DEV_W-1:0];
            s.sessions = n_sessions;
            s.slouch   = slouch_secs;
            s.longest  = longest_sec[pdd_pkg::DUR_W-1:0];
            s.since    = (last_up == 0 || secs_now < last_up) ? '0 : secs_now - last_up;
            return s;
        end
    endfunction

    task automatic write_setting(input logic [pdd_pkg::IDX_W-1:0] idx,
                                 input logic [pdd_pkg::WORD_W-1:0] data);
        logic [pdd_pkg::CFG_W-1:0] v;
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= data;
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            v = data[pdd_pkg::CFG_W-1:0];
            if (v < pdd_pkg::CFG_MIN)
            begin
                v = pdd_pkg::CFG_MIN;
            end
            else if (v > pdd_pkg::CFG_MAX)
            begin
                v = pdd_pkg::CFG_MAX;
            end
            case (idx)
                pdd_pkg::REG_THRESHOLD:    thr_deg  = v;
                pdd_pkg::REG_SUSTAIN:      sus_sec  = v;
                pdd_pkg::REG_RECOVER:      rec_sec  = v;
                pdd_pkg::REG_PRESET_BASE:  base_x10 = data[pdd_pkg::PITCH_W-1:0];
                pdd_pkg::REG_PRESET_VALID: calib    = data[0];
                default:
                begin
                end
            endcase
        end
    endtask

    task automatic send_reading(input pdd_pkg::opcode_t op,
                                input logic signed [pdd_pkg::PITCH_W-1:0] pitch,
                                input logic [pdd_pkg::WORD_W-1:0] now, input logic typed,
                                input pdd_pkg::posture_t t_post,
                                input logic [pdd_pkg::DEV_W-1:0] t_dev);
        status_t s;
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid  <= 1'b1;
            opcode    <= op;
            pitch_x10 <= pitch;
            now_ms    <= now;
            do @(posedge clk); while (!in_ready);
            s = track_posture(op, pitch, now);
            if (typed)
            begin
                s.posture = t_post;
                s.dev     = t_dev;
            end
            posture_status_q.push_back(s);
        end
    endtask

    // Holds the sender off until every pending status has come back.
    task automatic wait_for_results();
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while (posture_status_q.size() != 0);
        end
    endtask

    task automatic run_phase(input int ph);
        logic [pdd_pkg::WORD_W-1:0]         clock_ms;
        logic [pdd_pkg::WORD_W-1:0]         now;
        logic signed [pdd_pkg::PITCH_W-1:0] pitch;
        pdd_pkg::opcode_t                   op;
        logic                               high;
        int                                 run_left;
        int                                 n;
        int                                 r;
        int                                 lim;
        int                                 off;
        int                                 p;
        begin
            clock_ms = (ph % 2 == 1) ? 32'hFFFF_8000 : $urandom();
            high     = 1'b0;
            run_left = 0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                begin
                    wait_for_results();
                end
                r     = $urandom_range(99);
                now   = $urandom();
                pitch = pdd_pkg::PITCH_W'($urandom_range(0, 2047));
                if (r < 3)
                begin
                    op    = pdd_pkg::OP_CALIBRATE;
                    p     = int'($urandom_range(0, 600)) - 300;
                    pitch = p[pdd_pkg::PITCH_W-1:0];
                end
                else if (r < 5)
                begin
                    op = pdd_pkg::OP_STATS_CLEAR;
                end
                else if (r < 7)
                begin
                    op = pdd_pkg::OP_UNUSED;
                end
                else if (r < 12)
                begin
                    op = pdd_pkg::OP_TICK;
                end
                else
                begin
                    // Alternate dwell runs sized around the sustain and recovery settings.
                    op = pdd_pkg::OP_TICK;
                    if (run_left == 0)
                    begin
                        high     = !high;
                        run_left = (high ? int'(sus_sec) : int'(rec_sec))
                                   + int'($urandom_range(0, 4)) - 2;
                        if (run_left < 1)
                        begin
                            run_left = 1;
                        end
                    end
                    run_left = run_left - 1;
                    lim = int'(thr_deg) * 10;
                    if (high)
                    begin
                        off = lim + 1 + (($urandom_range(3) == 0) ? 0 : int'($urandom_range(0, 300)));
                    end
                    else
                    begin
                        off = ($urandom_range(3) == 0) ? lim : int'($urandom_range(0, lim));
                    end
                    p = ($urandom_range(1) == 1) ? int'(base_x10) + off : int'(base_x10) - off;
                    if (p > 1023 || p < -1024)
                    begin
                        p = 2 * int'(base_x10) - p;
                    end
                    if (p > 1023)
                    begin
                        p = 1023;
                    end
                    else if (p < -1024)
                    begin
                        p = -1024;
                    end
                    pitch    = p[pdd_pkg::PITCH_W-1:0];
                    clock_ms = clock_ms + 32'd1000 + pdd_pkg::WORD_W'($urandom_range(0, 30));
                    now      = clock_ms;
                end
                send_reading(op, pitch, now, 1'b0, pdd_pkg::POSTURE_UNKNOWN, '0);
            end
        end
    endtask

    task automatic check_field(input string what, input logic [pdd_pkg::WORD_W-1:0] want,
                               input logic [pdd_pkg::WORD_W-1:0] got);
        begin
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
                err_cnt++;
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (posture_status_q.size() == 0)
            begin
                $display("%0t: transaction with no status expected, expected none, actual posture %0d",
                         $time, posture);
                err_cnt++;
            end
            else
            begin
                want = posture_status_q.pop_front();
                check_field("posture", pdd_pkg::WORD_W'(want.posture),
                            pdd_pkg::WORD_W'(posture));
                check_field("deviation_x10", pdd_pkg::WORD_W'(want.dev),
                            pdd_pkg::WORD_W'($unsigned(deviation_x10)));
                check_field("session_count", want.sessions, session_count);
                check_field("slouch_time_sec", want.slouch, slouch_time_sec);
                check_field("longest_session_sec", pdd_pkg::WORD_W'(want.longest),
                            pdd_pkg::WORD_W'(longest_session_sec));
                check_field("since_upright_sec", want.since, since_upright_sec);
                check_field("event_valid", pdd_pkg::WORD_W'(want.evt_valid),
                            pdd_pkg::WORD_W'(event_valid));
                check_field("event_start_ms", want.evt_start, event_start_ms);
                check_field("event_duration_sec", pdd_pkg::WORD_W'(want.evt_dur),
                            pdd_pkg::WORD_W'(event_duration_sec));
                check_field("event_peak_dev_x10", pdd_pkg::WORD_W'(want.evt_peak),
                            pdd_pkg::WORD_W'(event_peak_dev_x10));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        int ph;
        int i;
        int k;
        thr_deg     = pdd_pkg::THRESHOLD_RST;
        sus_sec     = pdd_pkg::SUSTAIN_RST;
        rec_sec     = pdd_pkg::RECOVER_RST;
        base_x10    = '0;
        calib       = 1'b0;
        pstate      = pdd_pkg::POSTURE_UNKNOWN;
        above_cnt   = '0;
        below_cnt   = '0;
        sess_start  = '0;
        sess_peak   = '0;
        n_sessions  = '0;
        slouch_secs = '0;
        longest_sec = '0;
        last_up     = '0;
        secs_now    = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIR; i++)
        begin
            send_reading(DIR_ROWS[i].op, DIR_ROWS[i].pitch[pdd_pkg::PITCH_W-1:0],
                         DIR_ROWS[i].now, DIR_ROWS[i].typed, DIR_ROWS[i].post,
                         DIR_ROWS[i].dev[pdd_pkg::DEV_W-1:0]);
        end
        wait_for_results();

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            for (k = 0; k < N_REGS; k++)
            begin
                write_setting(pdd_pkg::reg_idx_t'(k), PHASE_CFG[ph][k]);
            end
            if (ph == 2)
            begin
                write_setting(REG_NONE, 32'hFFFF_FFFF);
            end
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            run_phase(ph);
            wait_for_results();
        end

        repeat (END_WAIT) @(posedge clk);
        if (err_cnt == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
